// ----- src/vssd_pkg.sv -----
// ============================================================================
// vssd_pkg: shared types and constants for the voice slot shadow block
// Word formats for the item and result channels, the shadow row layout,
// control groups between the sequencer and its units, and the field,
// status and register codes.
// ============================================================================
package vssd_pkg;

    // One desired voice, as it arrives on the item channel.
    typedef struct packed {
        logic [4:0]  slot_index;
        logic        want_active;
        logic [31:0] package_gen;
        logic [15:0] note_ident;
        logic [15:0] start_addr;
        logic [31:0] loop_bounds;
        logic [15:0] envelope;
        logic [15:0] release_req;
        logic [15:0] atten;
        logic [15:0] pitch;
        logic [15:0] pan_send;
        logic [15:0] key_ctrl;
    } item_t;

    // One register-write command or status word on the result channel.
    typedef struct packed {
        logic [4:0]  cmd_slot;
        logic [3:0]  cmd_field;
        logic [15:0] cmd_value;
        logic        has_cmd;
        logic        is_last;
        logic [1:0]  status;
        logic [31:0] fault_total;
        logic [31:0] stale_total;
        logic [31:0] emitted_total;
    } result_t;

    // Shadow copy of one voice slot.
    typedef struct packed {
        logic [31:0] gen;
        logic [15:0] note;
        logic [15:0] start;
        logic [31:0] loop_bounds;
        logic [15:0] envelope;
        logic [15:0] release_req;
        logic [15:0] atten;
        logic [15:0] pitch;
        logic [15:0] pan_send;
        logic [15:0] key_ctrl;
    } shadow_row_t;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] gen;
        logic [7:0]  room;
        logic [15:0] key_off;
    } cfg_t;

    // Sequencer requests to the shadow store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic live_set;
        logic live_clr;
    } shadow_ctl_t;

    // Sequencer requests to the shared compare unit.
    typedef struct packed {
        logic       clear;
        logic       step;
        logic [3:0] idx;
    } diff_ctl_t;

    // Accumulated compare results.
    typedef struct packed {
        logic       reassign;
        logic [7:0] change;
        logic [3:0] count;
    } diff_t;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_CLASSIFY,
        SEQ_DIFF,
        SEQ_CHECK,
        SEQ_EMIT,
        SEQ_DONE
    } seq_state_t;

    // Command field codes.
    localparam logic [3:0] FLD_KEY   = 4'd0;
    localparam logic [3:0] FLD_START = 4'd1;
    localparam logic [3:0] FLD_LSTRT = 4'd2;
    localparam logic [3:0] FLD_LEND  = 4'd3;
    localparam logic [3:0] FLD_ENV   = 4'd4;
    localparam logic [3:0] FLD_REL   = 4'd5;
    localparam logic [3:0] FLD_ATT   = 4'd6;
    localparam logic [3:0] FLD_PITCH = 4'd7;
    localparam logic [3:0] FLD_PAN   = 4'd8;

    // Status codes.
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_SLOT = 2'd1;
    localparam logic [1:0] STAT_CAP      = 2'd2;
    localparam logic [1:0] STAT_STALE    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GEN     = 2'd0;
    localparam logic [1:0] CFG_ROOM    = 2'd1;
    localparam logic [1:0] CFG_KEY_OFF = 2'd2;

    localparam logic [7:0]  ROOM_RESET    = 8'd10;
    localparam logic [15:0] KEY_OFF_RESET = 16'd4096;

    // Compare steps of the shared unit, one 16-bit pair per step.
    localparam logic [3:0] CMP_GEN_LO  = 4'd0;
    localparam logic [3:0] CMP_GEN_HI  = 4'd1;
    localparam logic [3:0] CMP_NOTE    = 4'd2;
    localparam logic [3:0] CMP_START   = 4'd3;
    localparam logic [3:0] CMP_LOOP_LO = 4'd4;
    localparam logic [3:0] CMP_LOOP_HI = 4'd5;
    localparam logic [3:0] CMP_ENV     = 4'd6;
    localparam logic [3:0] CMP_REL     = 4'd7;
    localparam logic [3:0] CMP_ATT     = 4'd8;
    localparam logic [3:0] CMP_PITCH   = 4'd9;
    localparam logic [3:0] CMP_PAN     = 4'd10;
    localparam logic [3:0] CMP_KEY     = 4'd11;

    // Command sequence positions: key off, start, loop start, loop end,
    // five words, final key control.
    localparam logic [3:0] FULL_SEQ = 4'd10;
    localparam logic [3:0] POS_KOFF = 4'd0;
    localparam logic [3:0] POS_KEY  = 4'd9;

endpackage

// ----- src/vssd_shadow.sv -----
// ============================================================================
// vssd_shadow: shadow store of the voice slots
// One row per slot in a memory with a registered read, plus a live flag per
// slot in flip-flops. A row's contents only count while its slot is live.
// ============================================================================
module vssd_shadow #(
    parameter int SLOTS   = 32,
    parameter int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vssd_pkg::shadow_ctl_t ctl,
    input  logic [SLOT_AW-1:0]   rd_addr,
    input  logic [SLOT_AW-1:0]   slot_addr,
    input  vssd_pkg::shadow_row_t wr_data,
    output vssd_pkg::shadow_row_t rd_data,
    output logic                 live
);
    import vssd_pkg::*;

    shadow_row_t      mem [SLOTS];
    shadow_row_t      rd_data_reg;
    logic [SLOTS-1:0] live_reg;
    logic [SLOTS-1:0] live_next;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[slot_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (ctl.live_set)
        begin
            live_next[slot_addr] = 1'b1;
        end
        if (ctl.live_clr)
        begin
            live_next[slot_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    assign rd_data = rd_data_reg;
    assign live    = live_reg[slot_addr];

endmodule

// ----- src/vssd_diff.sv -----
// ============================================================================
// vssd_diff: shared compare unit
// Compares one 16-bit pair of shadow and requested values per step and
// accumulates the reassignment flag, the change mask and the change count.
// ============================================================================
module vssd_diff (
    input  logic                  clk,
    input  logic                  rst_n,
    input  vssd_pkg::diff_ctl_t   ctl,
    input  vssd_pkg::shadow_row_t row,
    input  vssd_pkg::item_t       item,
    output vssd_pkg::diff_t       diff
);
    import vssd_pkg::*;

    logic [15:0] old_word;
    logic [15:0] new_word;
    logic        differs;
    logic [2:0]  change_idx;
    diff_t       diff_reg;
    diff_t       diff_next;

    always_comb
    begin
        case (ctl.idx)
            CMP_GEN_LO:  begin old_word = row.gen[15:0];          new_word = item.package_gen[15:0]; end
            CMP_GEN_HI:  begin old_word = row.gen[31:16];         new_word = item.package_gen[31:16]; end
            CMP_NOTE:    begin old_word = row.note;               new_word = item.note_ident; end
            CMP_START:   begin old_word = row.start;              new_word = item.start_addr; end
            CMP_LOOP_LO: begin old_word = row.loop_bounds[15:0];  new_word = item.loop_bounds[15:0]; end
            CMP_LOOP_HI: begin old_word = row.loop_bounds[31:16]; new_word = item.loop_bounds[31:16]; end
            CMP_ENV:     begin old_word = row.envelope;           new_word = item.envelope; end
            CMP_REL:     begin old_word = row.release_req;        new_word = item.release_req; end
            CMP_ATT:     begin old_word = row.atten;              new_word = item.atten; end
            CMP_PITCH:   begin old_word = row.pitch;              new_word = item.pitch; end
            CMP_PAN:     begin old_word = row.pan_send;           new_word = item.pan_send; end
            CMP_KEY:     begin old_word = row.key_ctrl;           new_word = item.key_ctrl; end
            default:     begin old_word = '0;                     new_word = '0; end
        endcase
    end

    assign differs    = (old_word != new_word);
    assign change_idx = 3'(ctl.idx - CMP_LOOP_LO);

    always_comb
    begin
        diff_next = diff_reg;
        if (ctl.clear)
        begin
            diff_next = '0;
        end
        else if (ctl.step)
        begin
            if (ctl.idx < CMP_LOOP_LO)
            begin
                diff_next.reassign = diff_reg.reassign | differs;
            end
            else
            begin
                diff_next.change[change_idx] = differs;
                diff_next.count = diff_reg.count + {3'b000, differs};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
        end
        else
        begin
            diff_reg <= diff_next;
        end
    end

    assign diff = diff_reg;

endmodule

// ----- src/vssd_seq.sv -----
// ============================================================================
// vssd_seq: sequencer of the voice slot shadow block
// Classifies each item, walks the shared compare unit over the fields,
// decides the command plan, updates the shadow and counters, and sends the
// result words through the output register.
// ============================================================================
module vssd_seq #(
    parameter int SLOTS   = 32,
    parameter int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vssd_pkg::item_t        item,
    input  logic                   item_valid,
    output logic                   item_ready,
    output vssd_pkg::result_t      result,
    output logic                   result_valid,
    input  logic                   result_ready,
    input  vssd_pkg::cfg_t         cfg,
    output vssd_pkg::shadow_ctl_t  shadow_ctl,
    output logic [SLOT_AW-1:0]     rd_addr,
    output logic [SLOT_AW-1:0]     slot_addr,
    output vssd_pkg::shadow_row_t  wr_row,
    input  logic                   live,
    output vssd_pkg::item_t        cur_item,
    output vssd_pkg::diff_ctl_t    diff_ctl,
    input  vssd_pkg::diff_t        diff
);
    import vssd_pkg::*;

    localparam int WIDE_W = SLOT_AW + 5;

    seq_state_t  state_reg;
    seq_state_t  state_next;
    item_t       item_reg;
    item_t       item_next;
    logic [1:0]  status_reg;
    logic [1:0]  status_next;
    logic [9:0]  plan_reg;
    logic [9:0]  plan_next;
    logic [3:0]  left_reg;
    logic [3:0]  left_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [3:0]  cmp_idx_reg;
    logic [3:0]  cmp_idx_next;
    logic [31:0] fault_cnt_reg;
    logic [31:0] fault_cnt_next;
    logic [31:0] stale_cnt_reg;
    logic [31:0] stale_cnt_next;
    logic [31:0] emit_cnt_reg;
    logic [31:0] emit_cnt_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    result_t     result_reg;
    result_t     result_next;

    logic [WIDE_W-1:0] cur_slot_wide;
    logic [WIDE_W-1:0] new_slot_wide;
    logic              in_range;
    logic              gen_ok;
    logic              reassigned;
    logic              out_free;
    logic [3:0]        pos_field;
    logic [15:0]       pos_value;

    assign cur_slot_wide = {{SLOT_AW{1'b0}}, item_reg.slot_index};
    assign new_slot_wide = {{SLOT_AW{1'b0}}, item.slot_index};
    assign in_range      = (cur_slot_wide < WIDE_W'(SLOTS));
    assign slot_addr     = cur_slot_wide[SLOT_AW-1:0];
    assign rd_addr       = new_slot_wide[SLOT_AW-1:0];
    assign gen_ok        = (cfg.gen != '0) && (item_reg.package_gen == cfg.gen);
    assign reassigned    = !live || diff.reassign;
    assign out_free      = !result_valid_reg || result_ready;

    assign wr_row.gen         = item_reg.package_gen;
    assign wr_row.note        = item_reg.note_ident;
    assign wr_row.start       = item_reg.start_addr;
    assign wr_row.loop_bounds = item_reg.loop_bounds;
    assign wr_row.envelope    = item_reg.envelope;
    assign wr_row.release_req = item_reg.release_req;
    assign wr_row.atten       = item_reg.atten;
    assign wr_row.pitch       = item_reg.pitch;
    assign wr_row.pan_send    = item_reg.pan_send;
    assign wr_row.key_ctrl    = item_reg.key_ctrl;

    assign cur_item = item_reg;

    // Field code and value of each position of the command sequence.
    always_comb
    begin
        case (pos_reg)
            4'd0:    begin pos_field = FLD_KEY;   pos_value = cfg.key_off; end
            4'd1:    begin pos_field = FLD_START; pos_value = item_reg.start_addr; end
            4'd2:    begin pos_field = FLD_LSTRT; pos_value = item_reg.loop_bounds[15:0]; end
            4'd3:    begin pos_field = FLD_LEND;  pos_value = item_reg.loop_bounds[31:16]; end
            4'd4:    begin pos_field = FLD_ENV;   pos_value = item_reg.envelope; end
            4'd5:    begin pos_field = FLD_REL;   pos_value = item_reg.release_req; end
            4'd6:    begin pos_field = FLD_ATT;   pos_value = item_reg.atten; end
            4'd7:    begin pos_field = FLD_PITCH; pos_value = item_reg.pitch; end
            4'd8:    begin pos_field = FLD_PAN;   pos_value = item_reg.pan_send; end
            default: begin pos_field = FLD_KEY;   pos_value = item_reg.key_ctrl; end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        item_next         = item_reg;
        status_next       = status_reg;
        plan_next         = plan_reg;
        left_next         = left_reg;
        pos_next          = pos_reg;
        cmp_idx_next      = cmp_idx_reg;
        fault_cnt_next    = fault_cnt_reg;
        stale_cnt_next    = stale_cnt_reg;
        emit_cnt_next     = emit_cnt_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        shadow_ctl        = '0;
        diff_ctl          = '0;
        diff_ctl.idx      = cmp_idx_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (item_valid)
                begin
                    item_next        = item;
                    shadow_ctl.rd_en = 1'b1;
                    diff_ctl.clear   = 1'b1;
                    cmp_idx_next     = CMP_GEN_LO;
                    pos_next         = POS_KOFF;
                    status_next      = STAT_OK;
                    state_next       = SEQ_CLASSIFY;
                end
            end

            SEQ_CLASSIFY:
            begin
                if (!in_range)
                begin
                    status_next = STAT_BAD_SLOT;
                    state_next  = SEQ_DONE;
                end
                else if (!item_reg.want_active)
                begin
                    state_next = SEQ_DONE;
                    if (live)
                    begin
                        if (cfg.room == '0)
                        begin
                            fault_cnt_next = fault_cnt_reg + 32'd1;
                            status_next    = STAT_CAP;
                        end
                        else
                        begin
                            plan_next           = 10'b00_0000_0001;
                            left_next           = 4'd1;
                            emit_cnt_next       = emit_cnt_reg + 32'd1;
                            shadow_ctl.live_clr = 1'b1;
                            state_next          = SEQ_EMIT;
                        end
                    end
                end
                else if (!gen_ok)
                begin
                    stale_cnt_next = stale_cnt_reg + 32'd1;
                    status_next    = STAT_STALE;
                    state_next     = SEQ_DONE;
                    if (live && (cfg.room != '0))
                    begin
                        plan_next           = 10'b00_0000_0001;
                        left_next           = 4'd1;
                        emit_cnt_next       = emit_cnt_reg + 32'd1;
                        shadow_ctl.live_clr = 1'b1;
                        state_next          = SEQ_EMIT;
                    end
                end
                else
                begin
                    state_next = SEQ_DIFF;
                end
            end

            SEQ_DIFF:
            begin
                diff_ctl.step = 1'b1;
                cmp_idx_next  = cmp_idx_reg + 4'd1;
                if (cmp_idx_reg == CMP_KEY)
                begin
                    state_next = SEQ_CHECK;
                end
            end

            SEQ_CHECK:
            begin
                state_next = SEQ_DONE;
                if (reassigned)
                begin
                    if (cfg.room < {4'b0000, FULL_SEQ})
                    begin
                        fault_cnt_next = fault_cnt_reg + 32'd1;
                        status_next    = STAT_CAP;
                    end
                    else
                    begin
                        plan_next           = '1;
                        left_next           = FULL_SEQ;
                        emit_cnt_next       = emit_cnt_reg + 32'(FULL_SEQ);
                        shadow_ctl.wr_en    = 1'b1;
                        shadow_ctl.live_set = 1'b1;
                        state_next          = SEQ_EMIT;
                    end
                end
                else if ({4'b0000, diff.count} > cfg.room)
                begin
                    fault_cnt_next = fault_cnt_reg + 32'd1;
                    status_next    = STAT_CAP;
                end
                else
                begin
                    shadow_ctl.wr_en    = 1'b1;
                    shadow_ctl.live_set = 1'b1;
                    if (diff.count != '0)
                    begin
                        plan_next     = {diff.change, 2'b00};
                        left_next     = diff.count;
                        emit_cnt_next = emit_cnt_reg + 32'(diff.count);
                        state_next    = SEQ_EMIT;
                    end
                end
            end

            SEQ_EMIT:
            begin
                if (!plan_reg[pos_reg])
                begin
                    pos_next = pos_reg + 4'd1;
                end
                else if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.cmd_slot      = item_reg.slot_index;
                    result_next.cmd_field     = pos_field;
                    result_next.cmd_value     = pos_value;
                    result_next.has_cmd       = 1'b1;
                    result_next.is_last       = (left_reg == 4'd1);
                    result_next.status        = status_reg;
                    result_next.fault_total   = fault_cnt_reg;
                    result_next.stale_total   = stale_cnt_reg;
                    result_next.emitted_total = emit_cnt_reg;
                    pos_next                  = pos_reg + 4'd1;
                    left_next                 = left_reg - 4'd1;
                    if (left_reg == 4'd1)
                    begin
                        state_next = SEQ_IDLE;
                    end
                end
            end

            SEQ_DONE:
            begin
                if (out_free)
                begin
                    result_valid_next         = 1'b1;
                    result_next.cmd_slot      = item_reg.slot_index;
                    result_next.cmd_field     = FLD_KEY;
                    result_next.cmd_value     = '0;
                    result_next.has_cmd       = 1'b0;
                    result_next.is_last       = 1'b1;
                    result_next.status        = status_reg;
                    result_next.fault_total   = fault_cnt_reg;
                    result_next.stale_total   = stale_cnt_reg;
                    result_next.emitted_total = emit_cnt_reg;
                    state_next                = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg       <= STAT_OK;
            plan_reg         <= '0;
            left_reg         <= '0;
            pos_reg          <= '0;
            cmp_idx_reg      <= '0;
            fault_cnt_reg    <= '0;
            stale_cnt_reg    <= '0;
            emit_cnt_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            status_reg       <= status_next;
            plan_reg         <= plan_next;
            left_reg         <= left_next;
            pos_reg          <= pos_next;
            cmp_idx_reg      <= cmp_idx_next;
            fault_cnt_reg    <= fault_cnt_next;
            stale_cnt_reg    <= stale_cnt_next;
            emit_cnt_reg     <= emit_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    assign item_ready   = (state_reg == SEQ_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // A command walk never starts or continues with nothing left to send.
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_EMIT |-> left_reg != 4'd0)
        else $error("command walk with no commands left");

    // Before the first command goes out, the plan holds exactly as many
    // commands as the walk will count down.
    a_plan_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_EMIT && pos_reg == POS_KOFF)
            |-> $countones(plan_reg) == int'(left_reg))
        else $error("command plan and command count disagree");

    // The emitted total only moves at a decision point, before any result.
    a_emit_total_at_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_cnt_reg != $past(emit_cnt_reg))
            |-> ($past(state_reg) == SEQ_CLASSIFY || $past(state_reg) == SEQ_CHECK))
        else $error("emitted total changed outside a decision");

    // A word marked last hands control back to the idle state.
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_EMIT && result_valid_next && !$stable(result_next)
            && result_next.is_last) |=> state_reg == SEQ_IDLE)
        else $error("last command did not end the item");

endmodule

// ----- src/voice_slot_shadow_diff_top.sv -----
// ============================================================================
// voice_slot_shadow_diff_top: voice slot shadow and register-write filter
// Keeps a shadow of every voice slot and turns each desired voice into the
// register-write commands that bring the slot there.
// ============================================================================
// Usage. The item channel (item_valid, item_ready, item) takes one desired
// voice per word. The result channel (result_valid, result_ready, result)
// returns one word per register-write command, or a single status word with
// has_cmd low when no command is needed; the last word of an item carries
// is_last. The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// current_generation (0), command_room (1) and key_off_value (2); it is always
// ready and is meant to be used only while no item is in flight.
// Timing. An item is taken, then classified in the next cycle; an item that
// plays compares its shadow field by field in a single shared 16-bit
// comparator, then decides the command plan. Commands leave one per cycle
// while the receiver is ready, and the walk steps over skipped sequence
// positions one by one. A bad slot or an idle key off skips the compare;
// the longest item sends the full ten-command sequence. One item is worked
// on at a time; item_ready is high only between items, and the next item
// may enter while the final word still waits in the output register.
// Reset clears the live flags, the counters and the configuration registers;
// slot rows need no clearing since a slot's row only counts while it is live.
// A stalled receiver simply holds the sequencer at the current command.
// ============================================================================
module voice_slot_shadow_diff_top #(
    parameter int SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  vssd_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output vssd_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import vssd_pkg::*;

    localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cfg_t                cfg_reg;
    cfg_t                cfg_next;
    shadow_ctl_t         shadow_ctl;
    logic [SLOT_AW-1:0]  rd_addr;
    logic [SLOT_AW-1:0]  slot_addr;
    shadow_row_t         wr_row;
    shadow_row_t         rd_row;
    logic                live;
    item_t               cur_item;
    diff_ctl_t           diff_ctl;
    diff_t               diff;

    // Configuration registers; a write to an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GEN:     cfg_next.gen     = cfg_data;
                CFG_ROOM:    cfg_next.room    = cfg_data[7:0];
                CFG_KEY_OFF: cfg_next.key_off = cfg_data[15:0];
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gen     <= '0;
            cfg_reg.room    <= ROOM_RESET;
            cfg_reg.key_off <= KEY_OFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vssd_shadow #(
        .SLOTS   (SLOTS),
        .SLOT_AW (SLOT_AW)
    ) u_shadow (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (shadow_ctl),
        .rd_addr   (rd_addr),
        .slot_addr (slot_addr),
        .wr_data   (wr_row),
        .rd_data   (rd_row),
        .live      (live)
    );

    vssd_diff u_diff (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (diff_ctl),
        .row   (rd_row),
        .item  (cur_item),
        .diff  (diff)
    );

    vssd_seq #(
        .SLOTS   (SLOTS),
        .SLOT_AW (SLOT_AW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cfg          (cfg_reg),
        .shadow_ctl   (shadow_ctl),
        .rd_addr      (rd_addr),
        .slot_addr    (slot_addr),
        .wr_row       (wr_row),
        .live         (live),
        .cur_item     (cur_item),
        .diff_ctl     (diff_ctl),
        .diff         (diff)
    );

endmodule
